// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the escape-time pixel RTL.
// Depends on a clock named clk and an active-low reset named arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/mbet_pkg.sv =====
// Shared types, constants and functions of the escape-time pixel unit.
// No dependencies; used by mbet_seq and mandelbrot_escape_time_pixel.
`timescale 1ns / 1ps

package mbet_pkg;

	localparam int MAX_ITER_DEF = 42;
	localparam int FRAC_BITS    = 27;
	localparam int SQ_W         = 36;
	localparam int SUM_W        = 44;
	localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W+1)'(4) << FRAC_BITS;

	typedef enum logic [1:0] {
		REG_ORIGIN_RE = 2'd0,
		REG_ORIGIN_IM = 2'd1,
		REG_STEP_RE   = 2'd2,
		REG_STEP_IM   = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_WAIT, ST_CRE, ST_CIM, ST_CIM_LD, ST_SQR, ST_SQI, ST_XRI, ST_TEST, ST_EMIT
	} step_t;

	typedef enum logic [2:0] {
		MUL_COL, MUL_ROW, MUL_RR, MUL_II, MUL_RI
	} mul_sel_t;

	typedef enum logic [1:0] {
		SEQ_NEXT, SEQ_WAIT_IN, SEQ_LOOP, SEQ_EMIT
	} seq_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     ld_cre;
		logic     ld_cim;
		logic     ld_sr;
		logic     ld_si;
		seq_op_t  seq;
		step_t    nxt;
		step_t    jmp;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic exit_now;
		logic out_free;
	} stat_t;

	typedef struct packed {
		ctrl_word_t cw;
		logic       take_in;
		logic       step_z;
		logic       emit;
		logic       in_ready;
	} seq_out_t;

	// Microprogram. The imaginary coordinate is loaded once, before the loop.
	// The loop body is SQR, SQI, XRI, TEST; TEST either advances z and jumps
	// back to SQR or leaves for EMIT.
	function automatic ctrl_word_t ucode(step_t pc);
		ctrl_word_t w;
		w = '{mul_sel: MUL_RR, ld_cre: 1'b0, ld_cim: 1'b0, ld_sr: 1'b0, ld_si: 1'b0,
			seq: SEQ_NEXT, nxt: ST_WAIT, jmp: ST_WAIT};
		unique case (pc)
			ST_WAIT: begin
				w.seq = SEQ_WAIT_IN;
				w.nxt = ST_CRE;
			end
			ST_CRE: begin
				w.mul_sel = MUL_COL;
				w.nxt     = ST_CIM;
			end
			ST_CIM: begin
				w.mul_sel = MUL_ROW;
				w.ld_cre  = 1'b1;
				w.nxt     = ST_CIM_LD;
			end
			ST_CIM_LD: begin
				w.mul_sel = MUL_RR;
				w.ld_cim  = 1'b1;
				w.nxt     = ST_SQR;
			end
			ST_SQR: begin
				w.mul_sel = MUL_RR;
				w.nxt     = ST_SQI;
			end
			ST_SQI: begin
				w.mul_sel = MUL_II;
				w.ld_sr   = 1'b1;
				w.nxt     = ST_XRI;
			end
			ST_XRI: begin
				w.mul_sel = MUL_RI;
				w.ld_si   = 1'b1;
				w.nxt     = ST_TEST;
			end
			ST_TEST: begin
				w.seq = SEQ_LOOP;
				w.nxt = ST_SQR;
				w.jmp = ST_EMIT;
			end
			ST_EMIT: begin
				w.seq = SEQ_EMIT;
				w.nxt = ST_WAIT;
			end
			default: ;
		endcase
		return w;
	endfunction

	// Clip a wide signed value to the signed 32-bit range.
	function automatic logic [31:0] sat32(logic [SUM_W-1:0] v);
		logic [SUM_W-32:0] hi;
		hi = v[SUM_W-1:31];
		if (&hi || ~|hi)
			return v[31:0];
		else if (v[SUM_W-1])
			return 32'h8000_0000;
		else
			return 32'h7FFF_FFFF;
	endfunction

endpackage

// ===== rtl/core/mbet_seq.sv =====
// Microcode sequencer of the escape-time pixel unit: step counter and control ROM.
// Depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  mbet_pkg::stat_t   stat,
	output mbet_pkg::seq_out_t ctl
);

	mbet_pkg::step_t    pc_q;
	mbet_pkg::step_t    pc_nxt;
	mbet_pkg::ctrl_word_t cw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mbet_pkg::ST_WAIT;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	always_comb begin
		cw          = mbet_pkg::ucode(pc_q);
		pc_nxt      = pc_q;
		ctl.cw      = cw;
		ctl.take_in = 1'b0;
		ctl.step_z  = 1'b0;
		ctl.emit    = 1'b0;
		ctl.in_ready = (cw.seq == mbet_pkg::SEQ_WAIT_IN);
		unique case (cw.seq)
			mbet_pkg::SEQ_NEXT: begin
				pc_nxt = cw.nxt;
			end
			mbet_pkg::SEQ_WAIT_IN: begin
				if (stat.in_valid) begin
					ctl.take_in = 1'b1;
					pc_nxt      = cw.nxt;
				end
			end
			mbet_pkg::SEQ_LOOP: begin
				if (stat.exit_now) begin
					pc_nxt = cw.jmp;
				end else begin
					ctl.step_z = 1'b1;
					pc_nxt     = cw.nxt;
				end
			end
			mbet_pkg::SEQ_EMIT: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					pc_nxt   = cw.nxt;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/mandelbrot_escape_time_pixel.sv =====
// Top level of the escape-time pixel unit: ports, registers and the shared datapath.
// Depends on mbet_pkg, mbet_seq and assert_macros.svh.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     column, row
// m_axis    out        m_axis_tvalid/tready     escape_count, inside_res, color_class
// cfg       in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// A pixel is accepted in the WAIT step, its point coordinates are formed in the
// CRE, CIM and CIM_LD steps, each iteration (at most MAX_ITER, 42 by default)
// runs the SQR, SQI, XRI and TEST steps, and the EMIT step writes the result
// to the output register. The unit takes no new pixel until EMIT returns to
// WAIT. The pace is set by the single 32x32 multiplier, which serves three products
// per iteration plus a compare-and-update step, all sequenced by the microprogram.
// Reset is asynchronous and active low; it loads the configuration defaults.
// The output register lets the next pixel be accepted while a result waits;
// the sequencer holds in its emit step only if a second result is ready first.

`include "assert_macros.svh"

module mandelbrot_escape_time_pixel #(
	parameter int MAX_ITER = mbet_pkg::MAX_ITER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [9:0] column, [19:10] row, [23:20] zero

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] escape_count, [8] inside_res,
	                                    // [11:9] color_class, [15:12] zero

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,      // register index, origin_re first
	input  logic [31:0] cfg_data
);

	localparam int SW = mbet_pkg::SUM_W;
	localparam int QW = mbet_pkg::SQ_W;
	localparam int FRAC_END = mbet_pkg::FRAC_BITS + QW - 1;

	// Configuration registers.
	logic [31:0] origin_re_q, origin_im_q;
	logic [30:0] step_re_q, step_im_q;

	// Datapath registers.
	logic [9:0]           col_q, row_q;
	logic signed [31:0]   cre_q, cim_q, zr_q, zi_q;
	logic signed [63:0]   prod_q;
	logic [QW-1:0]        sr_q, si_q;
	logic [7:0]           count_q;
	logic [2:0]           mod7_q;

	// Output register.
	logic                 out_valid_q;
	logic [7:0]           out_count_q;
	logic                 out_inside_q;
	logic [2:0]           out_class_q;

	mbet_pkg::stat_t      stat;
	mbet_pkg::seq_out_t   ctl;

	logic signed [31:0]   mul_a, mul_b;
	logic [QW:0]          mag_sum;
	logic                 at_limit;
	logic [SW-1:0]        cre_sum, cim_sum, zr_sum, zi_sum;
	logic [2:0]           cls;

	mbet_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	assign s_axis_tready = ctl.in_ready;
	assign cfg_ready     = 1'b1;

	// Configuration writes; the user must send them only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= 32'hF000_0000;
			origin_im_q <= 32'hF000_0000;
			step_re_q   <= 31'd1048576;
			step_im_q   <= 31'd1048576;
		end else if (cfg_valid) begin
			unique case (mbet_pkg::cfg_reg_t'(cfg_index))
				mbet_pkg::REG_ORIGIN_RE: origin_re_q <= cfg_data;
				mbet_pkg::REG_ORIGIN_IM: origin_im_q <= cfg_data;
				mbet_pkg::REG_STEP_RE:   step_re_q   <= cfg_data[30:0];
				mbet_pkg::REG_STEP_IM:   step_im_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection; the product is registered.
	always_comb begin
		unique case (ctl.cw.mul_sel)
			mbet_pkg::MUL_COL: begin
				mul_a = $signed({22'd0, col_q});
				mul_b = $signed({1'b0, step_re_q});
			end
			mbet_pkg::MUL_ROW: begin
				mul_a = $signed({22'd0, row_q});
				mul_b = $signed({1'b0, step_im_q});
			end
			mbet_pkg::MUL_RR: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
			mbet_pkg::MUL_II: begin
				mul_a = zi_q;
				mul_b = zi_q;
			end
			mbet_pkg::MUL_RI: begin
				mul_a = zr_q;
				mul_b = zi_q;
			end
			default: begin
				mul_a = zr_q;
				mul_b = zr_q;
			end
		endcase
	end

	// Point coordinates: origin plus the index product, clipped to Q5.27.
	assign cre_sum = {{(SW-32){origin_re_q[31]}}, origin_re_q} + prod_q[SW-1:0];
	assign cim_sum = {{(SW-32){origin_im_q[31]}}, origin_im_q} + prod_q[SW-1:0];

	// Squares are non-negative, so the floor shift is a plain part-select.
	// The escape test and the next z both work from the registered squares;
	// prod_q holds zr*zi in the test step, and bits [63:26] are its floor
	// shift by 26, which is the doubled cross term.
	assign mag_sum  = {1'b0, sr_q} + {1'b0, si_q};
	assign at_limit = (count_q >= 8'(MAX_ITER));
	assign zr_sum   = {{(SW-QW){1'b0}}, sr_q} - {{(SW-QW){1'b0}}, si_q}
		+ {{(SW-32){cre_q[31]}}, cre_q};
	assign zi_sum   = {{(SW-38){prod_q[63]}}, prod_q[63:26]}
		+ {{(SW-32){cim_q[31]}}, cim_q};

	assign stat.in_valid = s_axis_tvalid;
	assign stat.exit_now = (mag_sum > mbet_pkg::ESC_LIMIT) || at_limit;
	assign stat.out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (ctl.take_in) begin
			col_q <= s_axis_tdata[9:0];
			row_q <= s_axis_tdata[19:10];
		end
		if (ctl.cw.ld_cre) cre_q <= $signed(mbet_pkg::sat32(cre_sum));
		if (ctl.cw.ld_cim) cim_q <= $signed(mbet_pkg::sat32(cim_sum));
		if (ctl.cw.ld_sr)  sr_q  <= prod_q[FRAC_END:mbet_pkg::FRAC_BITS];
		if (ctl.cw.ld_si)  si_q  <= prod_q[FRAC_END:mbet_pkg::FRAC_BITS];
		if (ctl.take_in) begin
			zr_q <= '0;
			zi_q <= '0;
		end else if (ctl.step_z) begin
			zr_q <= $signed(mbet_pkg::sat32(zr_sum));
			zi_q <= $signed(mbet_pkg::sat32(zi_sum));
		end
		if (ctl.emit) begin
			out_count_q  <= at_limit ? 8'd0 : count_q;
			out_inside_q <= at_limit;
			out_class_q  <= cls;
		end
	end

	// Iteration count and its residue mod 7, kept side by side so the
	// colour class needs no division.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mod7_q  <= '0;
		end else if (ctl.take_in) begin
			count_q <= '0;
			mod7_q  <= '0;
		end else if (ctl.step_z) begin
			count_q <= count_q + 8'd1;
			mod7_q  <= (mod7_q == 3'd6) ? 3'd0 : mod7_q + 3'd1;
		end
	end

	// Colour class: 1 inside, residue plus one for residues 1 to 5, else 7.
	always_comb begin
		if (at_limit)
			cls = 3'd1;
		else if (mod7_q >= 3'd1 && mod7_q <= 3'd5)
			cls = mod7_q + 3'd1;
		else
			cls = 3'd7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_class_q, out_inside_q, out_count_q};

	// A result marked inside carries a zero count and the inside colour.
	`ASSERT_CLK(a_inside_fields, out_valid_q && out_inside_q |-> out_count_q == 8'd0 && out_class_q == 3'd1, "inside result with wrong fields")
	// An escaping result always has at least one iteration behind it.
	`ASSERT_CLK(a_escape_count, out_valid_q && !out_inside_q |-> out_count_q != 8'd0 && out_class_q != 3'd1, "escaping result with zero count")
	// The iteration counter never runs past the limit.
	`ASSERT_NEVER(a_count_limit, count_q > 8'(MAX_ITER), "iteration count beyond limit")
	// The residue counter stays in range and follows the count.
	`ASSERT_CLK(a_mod7_track, ctl.step_z |=> mod7_q == 3'((32'(count_q)) % 7), "mod 7 residue lost track")
	// A fresh item starts from a cleared count.
	`ASSERT_CLK(a_start_clear, ctl.take_in |=> count_q == 8'd0 && zr_q == 32'sd0, "item did not start cleared")

endmodule
